// File: design/cmt_pkg.sv
// ----------------------------------------------------------------------------
// Counted multiset table package
// Shared constants, command and status codes, and controller/datapath types.
// ----------------------------------------------------------------------------
package cmt_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_COUNT_BITS = 16;

  localparam int CMD_W    = 2;
  localparam int ELEM_W   = 32;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 16;
  localparam int TOTAL_W  = 22;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CNT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TOP = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOTF  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SAT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic start;
    logic rd_issue;
    logic rd_take;
    logic fin_walk;
    logic upd;
    logic init_next;
  } cmt_cmd_t;

  typedef struct packed {
    logic cur_nil;
    logic done_walk;
    logic init_done;
  } cmt_stat_t;

endpackage

// File: design/cmt_if.sv
// ----------------------------------------------------------------------------
// Counted multiset table channels
// Valid/ready interfaces for the command and result channels.
// ----------------------------------------------------------------------------
interface cmt_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [31:0] elem;
  modport source (output valid, output cmd, output elem, input ready);
  modport sink   (input valid, input cmd, input elem, output ready);
endinterface

interface cmt_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               found;
  logic [15:0]        occurrences;
  logic signed [31:0] top_elem;
  logic [21:0]        total_items;
  logic               is_empty;
  modport source (output valid, output status, output found, output occurrences,
                  output top_elem, output total_items, output is_empty, input ready);
  modport sink   (input valid, input status, input found, input occurrences,
                  input top_elem, input total_items, input is_empty, output ready);
endinterface

// File: design/counted_multiset_table_top.sv
// ----------------------------------------------------------------------------
// Counted multiset table
// Bag of signed 32-bit elements with counts, kept in a linked slot store.
//
//   channel  direction  payload
//   in       sink       cmd, elem
//   out      source     status, found, occurrences, top_elem, total_items,
//                       is_empty
//
// One command walks N entries, N being at most CAPACITY; the walk reads one
// slot at a time through the RAM port, issuing in S_RD and taking in S_TAKE.
// After reset the next-link store is initialised one slot at a time, with
// the input not ready. A stalled result holds the block until its transfer.
// A second link write after an append or an unlink can hold the input off
// until it is written.
// ----------------------------------------------------------------------------
module counted_multiset_table_top #(
  parameter int CAPACITY   = cmt_pkg::DEF_CAPACITY,
  parameter int COUNT_BITS = cmt_pkg::DEF_COUNT_BITS
) (
  input logic clk,
  input logic rst_n,
  cmt_in_if.sink    in_ch,
  cmt_out_if.source out_ch
);
  import cmt_pkg::*;

  cmt_cmd_t  ctl;
  cmt_stat_t sts;

  cmt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .ctl(ctl), .sts(sts)
  );

  cmt_datapath #(.CAPACITY(CAPACITY), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_cmd(in_ch.cmd), .in_elem(in_ch.elem),
    .res_status(out_ch.status), .res_found(out_ch.found),
    .res_occ(out_ch.occurrences), .res_top(out_ch.top_elem),
    .res_total(out_ch.total_items), .res_empty(out_ch.is_empty)
  );
endmodule

// File: design/cmt_ram.sv
// ----------------------------------------------------------------------------
// Counted multiset table RAM
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module cmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/cmt_datapath.sv
// ----------------------------------------------------------------------------
// Counted multiset table datapath
// Slot store, list pointers, walk registers and the update of one command.
// ----------------------------------------------------------------------------
module cmt_datapath #(
  parameter int CAPACITY   = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmt_pkg::cmt_cmd_t             ctl,
  output cmt_pkg::cmt_stat_t            sts,
  input  logic [1:0]                    in_cmd,
  input  logic [31:0]                   in_elem,
  output logic [2:0]                    res_status,
  output logic                          res_found,
  output logic [15:0]                   res_occ,
  output logic [31:0]                   res_top,
  output logic [21:0]                   res_total,
  output logic                          res_empty
);
  import cmt_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(CAPACITY + 1);
  localparam int TW = COUNT_BITS + IW + 1;
  localparam logic [PW-1:0]         NIL  = PW'(CAPACITY);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [PW-1:0] head_r, tail_r, free_r, cur_r, found_r, prev_r, next_r;
  logic [SW-1:0] steps_r;
  logic [TW-1:0] total_r;
  logic [1:0]    cmd_r;
  logic [31:0]   elem_r, top_r;
  logic [COUNT_BITS-1:0] best_r, fcnt_r;
  logic          have_r;
  logic [IW-1:0] init_r;

  logic [31:0] val_rd;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [PW-1:0] nxt_rd, prv_rd;

  logic val_we, cnt_we, nxt_we, prv_we;
  logic [IW-1:0] val_wa, cnt_wa, nxt_wa, prv_wa, rd_a;
  logic [31:0] val_wd;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic [PW-1:0] nxt_wd, prv_wd;

  // Second write to the next store for unlink or append is done in a separate
  // cycle through the pending registers.
  logic          pend_r;
  logic [IW-1:0] pend_a_r;
  logic [PW-1:0] pend_d_r;
  logic          pend2_r;
  logic [IW-1:0] pend2_a_r;
  logic [PW-1:0] pend2_d_r;

  logic [PW-1:0] pend_free_nxt;
  logic [PW-1:0] fnext_r;
  logic          frd_r;

  assign rd_a = ctl.rd_issue ? cur_r[IW-1:0] :
                ctl.fin_walk ? free_r[IW-1:0] : '0;

  cmt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (.clk(clk), .we(val_we),
    .waddr(val_wa), .wdata(val_wd), .raddr(rd_a), .rdata(val_rd));
  cmt_ram #(.WIDTH(COUNT_BITS), .DEPTH(CAPACITY)) u_cnt (.clk(clk), .we(cnt_we),
    .waddr(cnt_wa), .wdata(cnt_wd), .raddr(rd_a), .rdata(cnt_rd));
  cmt_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_nxt (.clk(clk), .we(nxt_we),
    .waddr(nxt_wa), .wdata(nxt_wd), .raddr(rd_a), .rdata(nxt_rd));
  cmt_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_prv (.clk(clk), .we(prv_we),
    .waddr(prv_wa), .wdata(prv_wd), .raddr(rd_a), .rdata(prv_rd));

  assign sts.cur_nil   = (cur_r >= NIL) || (steps_r == SW'(CAPACITY)) ||
                         (found_r != NIL);
  assign sts.done_walk = !pend_r && !pend2_r;
  assign sts.init_done = (init_r == IW'(CAPACITY - 1));

  logic is_add_new, full_add;
  assign is_add_new = (found_r == NIL);
  assign full_add   = is_add_new && (free_r >= NIL);

  always_comb begin
    val_we = 1'b0; val_wa = '0; val_wd = elem_r;
    cnt_we = 1'b0; cnt_wa = found_r[IW-1:0]; cnt_wd = fcnt_r;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = NIL;
    prv_we = 1'b0; prv_wa = '0; prv_wd = NIL;
    if (ctl.init_next) begin
      nxt_we = 1'b1; nxt_wa = init_r; nxt_wd = PW'(init_r) + PW'(1);
    end else if (pend_r) begin
      nxt_we = 1'b1; nxt_wa = pend_a_r; nxt_wd = pend_d_r;
    end else if (pend2_r) begin
      nxt_we = 1'b1; nxt_wa = pend2_a_r; nxt_wd = pend2_d_r;
    end
    if (ctl.upd) begin
      case (cmd_r)
        CMD_ADD: begin
          if (!is_add_new) begin
            cnt_we = (fcnt_r != CMAX);
            cnt_wd = fcnt_r + COUNT_BITS'(1);
          end else if (!full_add) begin
            val_we = 1'b1; val_wa = free_r[IW-1:0];
            cnt_we = 1'b1; cnt_wa = free_r[IW-1:0]; cnt_wd = COUNT_BITS'(1);
            prv_we = 1'b1; prv_wa = free_r[IW-1:0]; prv_wd = tail_r;
          end
        end
        CMD_REM: begin
          if (!is_add_new) begin
            cnt_we = 1'b1;
            cnt_wd = (fcnt_r != '0) ? fcnt_r - COUNT_BITS'(1) : fcnt_r;
            if (fcnt_r <= COUNT_BITS'(1) && next_r < NIL) begin
              prv_we = 1'b1; prv_wa = next_r[IW-1:0]; prv_wd = prev_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  logic [COUNT_BITS-1:0] occ_fin;
  always_comb begin
    occ_fin = '0;
    if (!is_add_new) begin
      if (cmd_r == CMD_ADD && fcnt_r != CMAX) occ_fin = fcnt_r + COUNT_BITS'(1);
      else if (cmd_r == CMD_REM && fcnt_r != '0) occ_fin = fcnt_r - COUNT_BITS'(1);
      else occ_fin = fcnt_r;
    end else if (cmd_r == CMD_ADD && !full_add) begin
      occ_fin = COUNT_BITS'(1);
    end
  end

  logic [TW-1:0] total_nxt;
  always_comb begin
    total_nxt = total_r;
    if (cmd_r == CMD_ADD && ((!is_add_new && fcnt_r != CMAX) || (is_add_new && !full_add)))
      total_nxt = total_r + TW'(1);
    else if (cmd_r == CMD_REM && !is_add_new && total_r != '0)
      total_nxt = total_r - TW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NIL; tail_r <= NIL; free_r <= '0; total_r <= '0;
      init_r <= '0; pend_r <= 1'b0; pend2_r <= 1'b0;
    end else begin
      if (ctl.init_next && !sts.init_done) init_r <= init_r + IW'(1);
      if (!ctl.init_next && pend_r) pend_r <= 1'b0;
      else if (!ctl.init_next && pend2_r) pend2_r <= 1'b0;
      if (ctl.start) begin
        cmd_r <= in_cmd; elem_r <= in_elem; cur_r <= head_r; steps_r <= '0;
        found_r <= NIL; have_r <= 1'b0; best_r <= '0; top_r <= '0;
      end
      if (ctl.rd_take) begin
        steps_r <= steps_r + SW'(1);
        cur_r   <= nxt_rd;
        if (cmd_r == CMD_TOP) begin
          if (!have_r || cnt_rd > best_r) begin
            best_r <= cnt_rd; top_r <= val_rd; have_r <= 1'b1;
          end
        end else if (val_rd == elem_r) begin
          found_r <= cur_r; fcnt_r <= cnt_rd; prev_r <= prv_rd; next_r <= nxt_rd;
        end
      end
      if (ctl.upd) begin
        total_r <= total_nxt;
        res_total <= 22'(total_nxt);
        res_empty <= (total_nxt == '0);
        res_found <= (cmd_r != CMD_TOP) && !is_add_new;
        res_top <= '0;
        res_occ <= 16'(occ_fin);
        res_status <= ST_OK;
        if (cmd_r == CMD_TOP) begin
          if (total_r == '0 || head_r >= NIL) begin
            res_status <= ST_EMPTY; res_occ <= '0;
          end else begin
            res_top <= top_r; res_occ <= 16'(best_r);
          end
        end else if (cmd_r == CMD_ADD) begin
          if (full_add) res_status <= ST_FULL;
          else if (!is_add_new && fcnt_r == CMAX) res_status <= ST_SAT;
          if (is_add_new && !full_add) begin
            free_r <= pend_free_nxt;
            pend_r <= 1'b1; pend_a_r <= free_r[IW-1:0]; pend_d_r <= NIL;
            if (tail_r < NIL) begin
              pend2_r <= 1'b1; pend2_a_r <= tail_r[IW-1:0]; pend2_d_r <= free_r;
            end else begin
              head_r <= free_r;
            end
            tail_r <= free_r;
          end
        end else if (is_add_new) begin
          res_status <= ST_NOTF;
        end else if (cmd_r == CMD_REM && fcnt_r <= COUNT_BITS'(1)) begin
          pend_r <= 1'b1; pend_a_r <= found_r[IW-1:0]; pend_d_r <= free_r;
          free_r <= found_r;
          if (prev_r < NIL) begin
            pend2_r <= 1'b1; pend2_a_r <= prev_r[IW-1:0]; pend2_d_r <= next_r;
          end else begin
            head_r <= next_r;
          end
          if (next_r >= NIL) tail_r <= prev_r;
        end
      end
    end
  end

  // Next free slot, read from the next store once the walk has finished.
  always_ff @(posedge clk) begin
    if (!rst_n) frd_r <= 1'b0;
    else frd_r <= ctl.fin_walk;
  end
  assign pend_free_nxt = fnext_r;
  always_ff @(posedge clk) begin
    if (frd_r) fnext_r <= nxt_rd;
  end
endmodule

// File: design/cmt_ctrl.sv
// ----------------------------------------------------------------------------
// Counted multiset table controller
// Sequences initialisation, the list walk, the update and the result transfer.
// ----------------------------------------------------------------------------
module cmt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output cmt_pkg::cmt_cmd_t  ctl,
  input  cmt_pkg::cmt_stat_t sts
);
  import cmt_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_TAKE = 3'd3;
  localparam logic [2:0] S_FREE = 3'd4;
  localparam logic [2:0] S_FRW  = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_INIT: begin
        ctl.init_next = 1'b1;
        if (sts.init_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = sts.done_walk;
        if (in_valid && sts.done_walk) begin
          ctl.start = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (sts.cur_nil) begin
          state_nxt = S_FREE;
        end else begin
          ctl.rd_issue = 1'b1;
          state_nxt = S_TAKE;
        end
      end
      S_TAKE: begin
        ctl.rd_take = 1'b1;
        state_nxt = S_RD;
      end
      S_FREE: begin
        ctl.fin_walk = 1'b1;
        state_nxt = S_FRW;
      end
      S_FRW: state_nxt = S_UPD;
      S_UPD: begin
        ctl.upd = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Counted multiset table testbench
// Drives add, remove, count and most-frequent commands into the block and
// checks every result, the typed rows of a short directed table against
// their own values and all else against a bag model kept in the bench.
// Directed rows come first; random phases then grow, fill and drain the store.
// ----------------------------------------------------------------------------
module tb_top;
  import cmt_pkg::*;

  localparam int CAP  = DEF_CAPACITY;
  localparam int NONE = CAP;
  localparam logic [OCC_W-1:0] COUNT_TOP = '1;
  localparam int POOL_SIZE = 80;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [OCC_W-1:0]    occurrences;
    logic [ELEM_W-1:0]   top_elem;
    logic [TOTAL_W-1:0]  total_items;
    logic                is_empty;
  } bag_result_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ELEM_W-1:0] elem;
    bit                typed;
    bag_result_t       want;
  } cmd_row_t;

  logic clk;
  logic rst_n;

  cmt_in_if  in_ch();
  cmt_out_if out_ch();

  counted_multiset_table_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [ELEM_W-1:0] bag_value[CAP];
  logic [OCC_W-1:0]  bag_count[CAP];
  int                bag_next[CAP];
  int                bag_prev[CAP];
  int                bag_head;
  int                bag_tail;
  int                bag_free;
  int                bag_used;
  longint            bag_total;

  bag_result_t       pending_results[$];
  logic [ELEM_W-1:0] elem_pool[POOL_SIZE];
  int                mismatches;
  int                gap_max;
  int                burst_left;
  int                stall_mode;
  int                stall_phase;
  cmd_row_t          directed[$];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int bag_locate(logic [ELEM_W-1:0] v);
    int cur;
    cur = bag_head;
    for (int n = 0; n < CAP && cur < NONE; n++) begin
      if (bag_value[cur] == v) return cur;
      cur = bag_next[cur];
    end
    return NONE;
  endfunction

  function automatic bag_result_t bag_apply(logic [CMD_W-1:0] c, logic [ELEM_W-1:0] v);
    bag_result_t r;
    int s;
    int n;
    int p;
    int nx;
    int cur;
    r = '0;
    r.status = ST_OK;
    if (c == CMD_TOP) begin
      if (bag_total == 0 || bag_head >= NONE) begin
        r.status = ST_EMPTY;
      end else begin
        cur = bag_head;
        for (int k = 0; k < CAP && cur < NONE; k++) begin
          if (k == 0 || bag_count[cur] > r.occurrences) begin
            r.occurrences = bag_count[cur];
            r.top_elem = bag_value[cur];
          end
          cur = bag_next[cur];
        end
      end
    end else begin
      s = bag_locate(v);
      r.found = (s < NONE);
      if (c == CMD_ADD) begin
        if (s < NONE) begin
          if (bag_count[s] == COUNT_TOP) begin
            r.status = ST_SAT;
          end else begin
            bag_count[s]++;
            bag_total++;
          end
          r.occurrences = bag_count[s];
        end else if (bag_free >= NONE) begin
          r.status = ST_FULL;
        end else begin
          n = bag_free;
          bag_free = bag_next[n];
          bag_value[n] = v;
          bag_count[n] = 1;
          bag_prev[n] = bag_tail;
          bag_next[n] = NONE;
          if (bag_tail < NONE) bag_next[bag_tail] = n;
          else bag_head = n;
          bag_tail = n;
          bag_total++;
          bag_used++;
          r.occurrences = 1;
        end
      end else if (s >= NONE) begin
        r.status = ST_NOTF;
      end else if (c == CMD_REM) begin
        bag_count[s]--;
        bag_total--;
        r.occurrences = bag_count[s];
        if (bag_count[s] == 0) begin
          p = bag_prev[s];
          nx = bag_next[s];
          if (p < NONE) bag_next[p] = nx;
          else bag_head = nx;
          if (nx < NONE) bag_prev[nx] = p;
          else bag_tail = p;
          bag_next[s] = bag_free;
          bag_free = s;
          bag_used--;
        end
      end else begin
        r.occurrences = bag_count[s];
      end
    end
    r.total_items = bag_total[TOTAL_W-1:0];
    r.is_empty = (bag_total == 0);
    return r;
  endfunction

  function automatic cmd_row_t row(logic [CMD_W-1:0] c, logic [ELEM_W-1:0] v, bit typed,
                                   logic [STATUS_W-1:0] st, logic fd, int oc,
                                   logic [ELEM_W-1:0] tp, int tot);
    cmd_row_t r;
    r.cmd = c;
    r.elem = v;
    r.typed = typed;
    r.want = '{st, fd, oc[OCC_W-1:0], tp, tot[TOTAL_W-1:0], tot == 0};
    return r;
  endfunction

  function automatic logic [ELEM_W-1:0] pick_live();
    int cur;
    int k;
    if (bag_used == 0) return elem_pool[$urandom_range(0, POOL_SIZE-1)];
    k = $urandom_range(0, bag_used-1);
    cur = bag_head;
    for (int n = 0; n < k; n++) cur = bag_next[cur];
    return bag_value[cur];
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [ELEM_W-1:0] v,
                          input bit typed, input bag_result_t want);
    bag_result_t r;
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= c;
    in_ch.elem  <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = bag_apply(c, v);
    pending_results.push_back(typed ? want : r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if (gap_max > 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  task automatic send_random(input int add_w, input int rem_w, input int cnt_w);
    logic [CMD_W-1:0]  c;
    logic [ELEM_W-1:0] v;
    int                roll;
    roll = $urandom_range(0, 99);
    if (roll < add_w) c = CMD_ADD;
    else if (roll < add_w + rem_w) c = CMD_REM;
    else if (roll < add_w + rem_w + cnt_w) c = CMD_CNT;
    else c = CMD_TOP;
    roll = $urandom_range(0, 99);
    if (roll < 8) v = $urandom;
    else if (c != CMD_ADD && roll < 60) v = pick_live();
    else v = elem_pool[$urandom_range(0, POOL_SIZE-1)];
    send_cmd(c, v, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    bag_result_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d occ %0d", $time,
                 out_ch.status, out_ch.occurrences);
        mismatches++;
      end else begin
        w = pending_results.pop_front();
        if (out_ch.status !== w.status) begin
          $display("%0t: status expected %0d actual %0d", $time, w.status, out_ch.status);
          mismatches++;
        end
        if (out_ch.found !== w.found) begin
          $display("%0t: found expected %0d actual %0d", $time, w.found, out_ch.found);
          mismatches++;
        end
        if (out_ch.occurrences !== w.occurrences) begin
          $display("%0t: occurrences expected %0d actual %0d", $time, w.occurrences,
                   out_ch.occurrences);
          mismatches++;
        end
        if (out_ch.top_elem !== w.top_elem) begin
          $display("%0t: top_elem expected %h actual %h", $time, w.top_elem,
                   out_ch.top_elem);
          mismatches++;
        end
        if (out_ch.total_items !== w.total_items) begin
          $display("%0t: total_items expected %0d actual %0d", $time, w.total_items,
                   out_ch.total_items);
          mismatches++;
        end
        if (out_ch.is_empty !== w.is_empty) begin
          $display("%0t: is_empty expected %0d actual %0d", $time, w.is_empty,
                   out_ch.is_empty);
          mismatches++;
        end
      end
    end
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      1: begin
        out_ch.ready <= ($urandom_range(0, 9) > 2);
      end
      2: begin
        out_ch.ready <= ((stall_phase % 11) > 3);
      end
      default: begin
        out_ch.ready <= 1'b1;
      end
    endcase
  end

  initial begin
    #50000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_ADD;
    in_ch.elem   = '0;
    rst_n        = 1'b0;
    stall_mode   = 0;
    gap_max      = 0;
    burst_left   = 0;
    for (int i = 0; i < CAP; i++) begin
      bag_value[i] = '0;
      bag_count[i] = '0;
      bag_prev[i]  = 0;
      bag_next[i]  = i + 1;
    end
    bag_head  = NONE;
    bag_tail  = NONE;
    bag_free  = 0;
    bag_used  = 0;
    bag_total = 0;
    elem_pool[0] = 32'h8000_0000;
    elem_pool[1] = 32'h7FFF_FFFF;
    elem_pool[2] = 32'h0000_0000;
    elem_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) elem_pool[i] = $urandom;

    directed.push_back(row(CMD_TOP, 32'h0000_1234, 1, ST_EMPTY, 0, 0, 0, 0));
    directed.push_back(row(CMD_REM, 32'h0000_0005, 1, ST_NOTF, 0, 0, 0, 0));
    directed.push_back(row(CMD_CNT, 32'h8000_0000, 1, ST_NOTF, 0, 0, 0, 0));
    directed.push_back(row(CMD_ADD, 32'h8000_0000, 1, ST_OK, 0, 1, 0, 1));
    directed.push_back(row(CMD_ADD, 32'h7FFF_FFFF, 1, ST_OK, 0, 1, 0, 2));
    directed.push_back(row(CMD_ADD, 32'h7FFF_FFFF, 1, ST_OK, 1, 2, 0, 3));
    directed.push_back(row(CMD_CNT, 32'h7FFF_FFFF, 1, ST_OK, 1, 2, 0, 3));
    directed.push_back(row(CMD_TOP, 32'hFFFF_FFFF, 1, ST_OK, 0, 2, 32'h7FFF_FFFF, 3));
    directed.push_back(row(CMD_ADD, 32'h8000_0000, 1, ST_OK, 1, 2, 0, 4));
    directed.push_back(row(CMD_TOP, 32'h0000_0000, 1, ST_OK, 0, 2, 32'h8000_0000, 4));
    directed.push_back(row(CMD_ADD, 32'h0000_0000, 1, ST_OK, 0, 1, 0, 5));
    directed.push_back(row(CMD_ADD, 32'hFFFF_FFFF, 1, ST_OK, 0, 1, 0, 6));
    directed.push_back(row(CMD_REM, 32'h8000_0000, 1, ST_OK, 1, 1, 0, 5));
    directed.push_back(row(CMD_REM, 32'h8000_0000, 1, ST_OK, 1, 0, 0, 4));
    directed.push_back(row(CMD_CNT, 32'h8000_0000, 1, ST_NOTF, 0, 0, 0, 4));
    directed.push_back(row(CMD_REM, 32'h0000_0000, 1, ST_OK, 1, 0, 0, 3));
    directed.push_back(row(CMD_ADD, 32'h5555_5555, 1, ST_OK, 0, 1, 0, 4));
    directed.push_back(row(CMD_TOP, 32'h5555_5555, 1, ST_OK, 0, 2, 32'h7FFF_FFFF, 4));
    directed.push_back(row(CMD_REM, 32'hFFFF_FFFF, 1, ST_OK, 1, 0, 0, 3));
    directed.push_back(row(CMD_REM, 32'h7FFF_FFFF, 1, ST_OK, 1, 1, 0, 2));
    directed.push_back(row(CMD_REM, 32'h7FFF_FFFF, 1, ST_OK, 1, 0, 0, 1));
    directed.push_back(row(CMD_REM, 32'h5555_5555, 1, ST_OK, 1, 0, 0, 0));
    directed.push_back(row(CMD_TOP, 32'hAAAA_AAAA, 1, ST_EMPTY, 0, 0, 0, 0));
    directed.push_back(row(CMD_ADD, 32'hAAAA_AAAA, 0, ST_OK, 0, 0, 0, 0));
    directed.push_back(row(CMD_CNT, 32'hAAAA_AAAA, 0, ST_OK, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_cmd(directed[i].cmd, directed[i].elem, directed[i].typed,
                                   directed[i].want);

    // The store is grown, filled past capacity and drained in turn, with the
    // idling of both sides changed from one phase to the next.
    for (int ph = 0; ph < 6; ph++) begin
      gap_max    = (ph % 2 == 0) ? 0 : 6;
      stall_mode = ph % 3;
      for (int k = 0; k < 240; k++) begin
        case (ph % 3)
          0: begin
            send_random(40, 30, 15);
          end
          1: begin
            send_random(80, 7, 7);
          end
          default: begin
            send_random(15, 70, 8);
          end
        endcase
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
